@@ design/spp_pkg.sv @@
// Package for the substitution pattern pixel core: sizes, register indexes,
// the pipeline record and the per-stage digit and walk functions.
// Depends on nothing; imported by substitution_pattern_pixel_core.
`default_nettype none

package spp_pkg;

  // Pattern limits.
  localparam int MAX_BLOCK   = 4;
  localparam int NUM_SYMBOLS = 4;
  localparam int MAX_LEVELS  = 8;

  // Field widths.
  localparam int COORD_W  = 16;
  localparam int SYM_W    = 2;
  localparam int DIG_W    = 2;
  localparam int LVL_CNT_W = 4;
  localparam int LVL_IDX_W = 3;
  localparam int BLK_W    = 3;
  localparam int MASK_W   = 4;
  localparam int RULE_W   = 64;
  localparam int HALF_W   = 32;
  localparam int COLOR_W  = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // One stage per digit extraction, then one stage per substitution level.
  localparam int NUM_STAGES = 2 * MAX_LEVELS;

  // Color levels.
  localparam logic [COLOR_W-1:0] COLOR_ON  = 8'd255;
  localparam logic [COLOR_W-1:0] COLOR_OFF = 8'd0;

  // Reciprocal of 3 for a 16-bit dividend: (x * 0xAAAB) >> 17 is exact.
  localparam logic [16:0] RECIP3       = 17'h0AAAB;
  localparam int          RECIP3_SHIFT = 17;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_ROWS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COLS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_SYMBOL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RULE_MASK    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RULE_LOW     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RULE_HIGH    = 3'd6;

  // Record that travels down the pipeline.
  typedef struct packed {
    logic [COORD_W-1:0]                  quo_row;
    logic [COORD_W-1:0]                  quo_col;
    logic [MAX_LEVELS-1:0][DIG_W-1:0]    dig_row;
    logic [MAX_LEVELS-1:0][DIG_W-1:0]    dig_col;
    logic [SYM_W-1:0]                    sym;
    logic                                missing;
  } pipe_t;

  typedef struct packed {
    logic [COORD_W-1:0] quo;
    logic [DIG_W-1:0]   rem;
  } divres_t;

  // Block size clamp: zero acts as one, anything above MAX_BLOCK as MAX_BLOCK.
  function automatic logic [BLK_W-1:0] clamp_block(input logic [BLK_W-1:0] v);
    logic [BLK_W-1:0] r;
    if (v == '0) begin
      r = BLK_W'(1);
    end else if (v > BLK_W'(MAX_BLOCK)) begin
      r = BLK_W'(MAX_BLOCK);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Divide a coordinate by a radix of 1 to 4, giving quotient and digit.
  function automatic divres_t div_radix(input logic [COORD_W-1:0] x,
                                        input logic [BLK_W-1:0] radix);
    divres_t            res;
    logic [32:0]        prod;
    logic [COORD_W-1:0] back;
    prod = 33'(x) * 33'(RECIP3);
    unique case (radix)
      3'd2: begin
        res.quo = x >> 1;
        res.rem = {1'b0, x[0]};
      end
      3'd3: begin
        res.quo = prod[RECIP3_SHIFT +: COORD_W];
        back    = res.quo + (res.quo << 1);
        res.rem = DIG_W'(x - back);
      end
      3'd4: begin
        res.quo = x >> 2;
        res.rem = x[1:0];
      end
      default: begin
        res.quo = x;
        res.rem = '0;
      end
    endcase
    return res;
  endfunction

  // Rule cell lookup: symbol picks the 32-bit half, (r, c) the 2-bit cell.
  function automatic logic [SYM_W-1:0] rule_cell(input logic [SYM_W-1:0] sym,
                                                 input logic [DIG_W-1:0] r,
                                                 input logic [DIG_W-1:0] c,
                                                 input logic [RULE_W-1:0] lo,
                                                 input logic [RULE_W-1:0] hi);
    logic [RULE_W-1:0] word;
    logic [HALF_W-1:0] half;
    logic [4:0]        bitpos;
    word   = sym[1] ? hi : lo;
    half   = sym[0] ? word[RULE_W-1:HALF_W] : word[HALF_W-1:0];
    bitpos = {r, c, 1'b0};
    return half[bitpos +: SYM_W];
  endfunction

  // Digit stage: peel off the least significant row and column digits.
  function automatic pipe_t digit_step(input pipe_t p,
                                       input logic [LVL_CNT_W-1:0] step,
                                       input logic [LVL_CNT_W-1:0] levels,
                                       input logic [BLK_W-1:0] br,
                                       input logic [BLK_W-1:0] bc);
    pipe_t   q;
    divres_t dr;
    divres_t dc;
    q  = p;
    dr = div_radix(p.quo_row, br);
    dc = div_radix(p.quo_col, bc);
    if (step < levels) begin
      q.quo_row = dr.quo;
      q.quo_col = dc.quo;
      q.dig_row[step[LVL_IDX_W-1:0]] = dr.rem;
      q.dig_col[step[LVL_IDX_W-1:0]] = dc.rem;
    end
    return q;
  endfunction

  // Walk stage: substitute one level, most significant digit first.
  function automatic pipe_t walk_step(input pipe_t p,
                                      input logic [LVL_CNT_W-1:0] step,
                                      input logic [LVL_CNT_W-1:0] levels,
                                      input logic [MASK_W-1:0] mask,
                                      input logic [RULE_W-1:0] lo,
                                      input logic [RULE_W-1:0] hi);
    pipe_t                 q;
    logic [LVL_IDX_W-1:0]  sel;
    q   = p;
    sel = LVL_IDX_W'(levels - step - LVL_CNT_W'(1));
    if (step < levels && !p.missing) begin
      if (mask[p.sym]) begin
        q.sym = rule_cell(p.sym, p.dig_row[sel], p.dig_col[sel], lo, hi);
      end else begin
        q.missing = 1'b1;
      end
    end
    return q;
  endfunction

endpackage

`default_nettype wire

@@ design/substitution_pattern_pixel_core.sv @@
// Substitution pattern pixel core: cell coordinate in, symbol and color out.
// Depends on spp_pkg for sizes, register indexes and the stage functions.
//
// Usage:
//   Input channel (in_valid/in_ready, cell_row, cell_col) carries one cell
//   coordinate per transaction. Output channel (out_valid/out_ready) carries
//   the final symbol, in_range, rule_missing and the red/green/blue color.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   one register per transaction; cfg_ready is always high and indexes past
//   the register list are dropped. Write configuration only while idle.
//   The datapath is a 16-stage pipeline plus an output register: eight
//   stages peel off one row and one column digit each (shift for radix 2
//   and 4, reciprocal multiply for radix 3), then eight stages each apply
//   one substitution level. One coordinate can enter every cycle unless
//   the output stalls.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and in_ready drops; nothing is lost or repeated.
//   Reset clears all valid bits and loads the register reset values:
//   level_count 0, block 2 by 2, start symbol 0, all rules present,
//   rule words 0.
`default_nettype none

module substitution_pattern_pixel_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [spp_pkg::COORD_W-1:0]      cell_row,
  input  wire logic [spp_pkg::COORD_W-1:0]      cell_col,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [spp_pkg::SYM_W-1:0]             symbol,
  output logic                                  in_range,
  output logic                                  rule_missing,
  output logic [spp_pkg::COLOR_W-1:0]           red,
  output logic [spp_pkg::COLOR_W-1:0]           green,
  output logic [spp_pkg::COLOR_W-1:0]           blue,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [spp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [spp_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import spp_pkg::*;

  // Configuration registers.
  logic [LVL_CNT_W-1:0] level_count;
  logic [BLK_W-1:0]     block_rows;
  logic [BLK_W-1:0]     block_cols;
  logic [SYM_W-1:0]     start_symbol;
  logic [MASK_W-1:0]    rule_present_mask;
  logic [RULE_W-1:0]    rule_cells_low;
  logic [RULE_W-1:0]    rule_cells_high;

  // Clamped views used by every stage.
  logic [LVL_CNT_W-1:0] levels;
  logic [BLK_W-1:0]     br;
  logic [BLK_W-1:0]     bc;

  // Pipeline state.
  logic [NUM_STAGES-1:0] vld;
  pipe_t                 stg      [NUM_STAGES];
  pipe_t                 stg_in   [NUM_STAGES];
  pipe_t                 stg_next [NUM_STAGES];
  pipe_t                 head;
  pipe_t                 last;
  logic                  adv;
  logic                  fits;

  // Register writes; the port never pushes back.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_count       <= '0;
      block_rows        <= BLK_W'(2);
      block_cols        <= BLK_W'(2);
      start_symbol      <= '0;
      rule_present_mask <= '1;
      rule_cells_low    <= '0;
      rule_cells_high   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LEVEL_COUNT:  level_count       <= cfg_data[LVL_CNT_W-1:0];
        REG_BLOCK_ROWS:   block_rows        <= cfg_data[BLK_W-1:0];
        REG_BLOCK_COLS:   block_cols        <= cfg_data[BLK_W-1:0];
        REG_START_SYMBOL: start_symbol      <= cfg_data[SYM_W-1:0];
        REG_RULE_MASK:    rule_present_mask <= cfg_data[MASK_W-1:0];
        REG_RULE_LOW:     rule_cells_low    <= cfg_data;
        REG_RULE_HIGH:    rule_cells_high   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Clamp the block sizes and the level count.
  assign br     = clamp_block(block_rows);
  assign bc     = clamp_block(block_cols);
  assign levels = (level_count > LVL_CNT_W'(MAX_LEVELS)) ? LVL_CNT_W'(MAX_LEVELS)
                                                         : level_count;

  // The pipeline moves whenever the output register is free or being taken.
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Record entering the first stage.
  always_comb begin
    head         = '0;
    head.quo_row = cell_row;
    head.quo_col = cell_col;
    head.sym     = start_symbol;
  end

  // Stage logic: digit extraction first, then the substitution walk.
  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign stg_in[s] = head;
    end else begin : g_mid
      assign stg_in[s] = stg[s-1];
    end

    if (s < MAX_LEVELS) begin : g_digit
      assign stg_next[s] = digit_step(stg_in[s], LVL_CNT_W'(s), levels, br, bc);
    end else begin : g_walk
      assign stg_next[s] = walk_step(stg_in[s], LVL_CNT_W'(s - MAX_LEVELS), levels,
                                     rule_present_mask, rule_cells_low,
                                     rule_cells_high);
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        stg[s] <= stg_next[s];
      end
    end
  end

  // Valid bits travel alongside the records.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NUM_STAGES-2:0], in_valid};
    end
  end

  // Range check: all quotient bits must be gone after the digit stages.
  assign last = stg[NUM_STAGES-1];
  assign fits = (last.quo_row == '0) && (last.quo_col == '0);

  // Output register with color mapping.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[NUM_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_range     <= fits;
      rule_missing <= fits && last.missing;
      symbol       <= (fits && !last.missing) ? last.sym : '0;
      red          <= fits ? COLOR_OFF : COLOR_ON;
      green        <= fits ? COLOR_OFF : COLOR_ON;
      blue         <= !fits ? COLOR_ON
                    : (!last.missing && last.sym[0]) ? COLOR_ON : COLOR_OFF;
    end
  end

endmodule

`default_nettype wire
